[src/bpfa_pkg.sv]
// Package for the bitmap page frame allocator.
// Holds the controller state type, command codes and fixed datapath widths.
// No dependencies; imported by the allocator top level and its checker.
package bpfa_pkg;

  typedef enum logic [1:0] {
    CMD_MARK_USED = 2'd0,
    CMD_MARK_FREE = 2'd1,
    CMD_ALLOCATE  = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_SETUP,
    ST_MARK,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  // Frame arithmetic: start frame plus page count reaches up to 2^21 - 1.
  localparam int unsigned FRAME_CALC_W = 22;
  // Byte arithmetic: holds a bitmap byte count up to 2^17.
  localparam int unsigned BYTE_CALC_W  = 18;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 72;

endpackage

[src/bitmap_page_frame_allocator.sv]
// Bitmap page frame allocator: one used bit per 4 KiB frame in a byte-wide RAM.
// Depends on bpfa_pkg for the command codes, state type and datapath widths.
// Use: each input transaction carries a command (mark range used, mark range
// free, allocate one frame) and yields exactly one output transaction with the
// granted frame address, the grant flag and the running grant count.
// The lowest allocatable frame is written on the cfg channel, which is always
// ready; write it only while no command is in flight.
// After reset the block sweeps the bitmap RAM to all ones, one byte per cycle,
// so s_axis_tready stays low until all BITMAP_BYTES bytes (8192 by default) are written.
// Each command steps through ST_CALC and ST_SETUP, then ST_MARK for a mark or
// ST_SEARCH for an allocate, and ends in ST_FINISH, which loads the output
// register once it is free and raises m_axis_tvalid; an unused command goes
// from ST_CALC to ST_FINISH, and an empty mark range or search window skips
// the walk. With the receiver ready, s_axis_tready rises with m_axis_tvalid.
// The walk speed is set by the single read and write port of the RAM.
// The result sits in an output register; a new command is accepted while it
// waits, but that command's result is held back until the receiver takes the
// earlier one (m_axis_tvalid stays high and the data holds while tready is low).
module bitmap_page_frame_allocator
  import bpfa_pkg::*;
#(
  parameter int unsigned NUM_FRAMES   = 65536,
  parameter int unsigned BITMAP_BYTES = 8192
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data,      // lowest_alloc_frame
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] command, [33:2] base_address, [65:34] range_bytes, [71:66] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] frame_address, [32] granted, [64:33] grants_total, [71:65] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned BYTE_W  = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int unsigned FRAME_W = $clog2(NUM_FRAMES);
  localparam logic [FRAME_CALC_W-1:0] NF_C = FRAME_CALC_W'(NUM_FRAMES);
  localparam logic [FRAME_CALC_W-1:0] BF_C = FRAME_CALC_W'(BITMAP_BYTES * 8);
  localparam logic [BYTE_CALC_W-1:0]  BB_C = BYTE_CALC_W'(BITMAP_BYTES);
  localparam logic [BYTE_W-1:0]       LAST_BYTE = BYTE_W'(BITMAP_BYTES - 1);

  state_t state, state_next;

  logic [7:0] bitmap [BITMAP_BYTES];
  logic [7:0] rdata;

  cmd_t                    cmd;
  logic [31:0]             base;
  logic [31:0]             size;
  logic [FRAME_CALC_W-1:0] first_f;
  logic [FRAME_CALC_W-1:0] stop_f;
  logic [15:0]             lowest_alloc_frame;
  logic [FRAME_W-1:0]      highest_freed;
  logic [BYTE_W-1:0]       last_hit;
  logic [31:0]             grant_count;
  logic [BYTE_W-1:0]       clr_addr;
  logic [BYTE_CALC_W-1:0]  win_lo;
  logic [BYTE_CALC_W-1:0]  win_hi;
  logic [BYTE_W-1:0]       byte_first;
  logic [BYTE_W-1:0]       byte_last;
  logic [2:0]              bit_first;
  logic [2:0]              bit_last;
  logic [BYTE_CALC_W-1:0]  rd_addr;
  logic [BYTE_CALC_W-1:0]  issue_left;
  logic                    rd_pend;
  logic [BYTE_W-1:0]       pend_addr;
  logic [31:0]             res_addr;
  logic                    res_granted;
  logic [31:0]             out_addr;
  logic                    out_granted;
  logic [31:0]             out_count;

  // Combinational control and datapath signals.
  logic                    accept;
  logic                    mem_re;
  logic                    mem_we;
  logic [BYTE_W-1:0]       mem_wa;
  logic [7:0]              mem_wd;
  logic                    hit;
  logic [2:0]              zero_bit;
  logic [2:0]              lo_bit;
  logic [2:0]              hi_bit;
  logic [7:0]              mark_mask;
  logic [BYTE_CALC_W-1:0]  addr_inc;
  logic [BYTE_CALC_W-1:0]  addr_adv;
  logic [32:0]             round_sum;
  logic [32:0]             base_up;
  logic [31:0]             end_addr;
  logic [FRAME_CALC_W-1:0] stop_n;
  logic [FRAME_CALC_W-1:0] stop_b;
  logic [FRAME_CALC_W-1:0] last_f;
  logic [FRAME_CALC_W-1:0] hff_ext;
  logic [BYTE_CALC_W-1:0]  hi_raw;
  logic [BYTE_CALC_W-1:0]  last_hit_ext;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {7'd0, out_count, out_granted, out_addr};

  assign round_sum    = {1'b0, size} + 33'h0_0000_0FFF;
  assign base_up      = {1'b0, base} + 33'h0_0000_0FFF;
  assign end_addr     = base + size;
  assign hff_ext      = FRAME_CALC_W'(highest_freed);
  assign hi_raw       = BYTE_CALC_W'(highest_freed >> 3) + BYTE_CALC_W'(1);
  assign last_hit_ext = BYTE_CALC_W'(last_hit);
  assign stop_n       = (stop_f > NF_C) ? NF_C : stop_f;
  assign stop_b       = (stop_n > BF_C) ? BF_C : stop_n;
  assign last_f       = stop_b - FRAME_CALC_W'(1);

  assign addr_inc = rd_addr + BYTE_CALC_W'(1);
  assign addr_adv = (state == ST_SEARCH && addr_inc == win_hi) ? win_lo : addr_inc;

  assign hit = rd_pend && (rdata != 8'hFF);

  always_comb begin
    zero_bit = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!rdata[i]) begin
        zero_bit = 3'(i);
      end
    end
  end

  assign lo_bit    = (pend_addr == byte_first) ? bit_first : 3'd0;
  assign hi_bit    = (pend_addr == byte_last) ? bit_last : 3'd7;
  assign mark_mask = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));

  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = pend_addr;
    mem_wd     = rdata;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = 8'hFF;
        if (clr_addr == LAST_BYTE) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = (cmd == CMD_NONE) ? ST_FINISH : ST_SETUP;
      end
      ST_SETUP: begin
        if (cmd == CMD_ALLOCATE) begin
          state_next = (win_lo < win_hi) ? ST_SEARCH : ST_FINISH;
        end else begin
          state_next = (first_f < stop_b) ? ST_MARK : ST_FINISH;
        end
      end
      ST_MARK: begin
        mem_re = (issue_left != '0);
        mem_we = rd_pend;
        mem_wd = (cmd == CMD_MARK_USED) ? (rdata | mark_mask) : (rdata & ~mark_mask);
        if (!rd_pend && issue_left == '0) begin
          state_next = ST_FINISH;
        end
      end
      ST_SEARCH: begin
        mem_re = (issue_left != '0) && !hit;
        mem_we = hit;
        mem_wd = rdata | (8'd1 << zero_bit);
        if (hit || (!rd_pend && issue_left == '0)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= bitmap[rd_addr[BYTE_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr           <= '0;
      lowest_alloc_frame <= '0;
      highest_freed      <= '0;
      last_hit           <= '0;
      grant_count        <= '0;
      rd_pend            <= 1'b0;
      issue_left         <= '0;
      m_axis_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lowest_alloc_frame <= cfg_data;
      end
      if (state == ST_FINISH && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + BYTE_W'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            cmd         <= cmd_t'(s_axis_tdata[1:0]);
            base        <= s_axis_tdata[33:2];
            size        <= s_axis_tdata[65:34];
            res_addr    <= '0;
            res_granted <= 1'b0;
          end
        end
        ST_CALC: begin
          if (cmd == CMD_MARK_USED) begin
            first_f <= FRAME_CALC_W'(base[31:12]);
            stop_f  <= FRAME_CALC_W'(base[31:12]) + FRAME_CALC_W'(round_sum[32:12]);
          end else begin
            first_f <= FRAME_CALC_W'(base_up[32:12]);
            stop_f  <= FRAME_CALC_W'(end_addr[31:12]);
          end
          win_lo <= BYTE_CALC_W'(lowest_alloc_frame[15:3]);
          win_hi <= (hi_raw > BB_C) ? BB_C : hi_raw;
        end
        ST_SETUP: begin
          rd_pend <= 1'b0;
          if (cmd == CMD_ALLOCATE) begin
            rd_addr    <= (last_hit_ext >= win_lo && last_hit_ext < win_hi) ?
                          last_hit_ext : win_lo;
            issue_left <= win_hi - win_lo;
          end else begin
            if (cmd == CMD_MARK_FREE && first_f < stop_n &&
                stop_n - FRAME_CALC_W'(1) > hff_ext) begin
              highest_freed <= FRAME_W'(stop_n - FRAME_CALC_W'(1));
            end
            byte_first <= first_f[BYTE_W+2:3];
            byte_last  <= last_f[BYTE_W+2:3];
            bit_first  <= first_f[2:0];
            bit_last   <= last_f[2:0];
            rd_addr    <= BYTE_CALC_W'(first_f[FRAME_CALC_W-1:3]);
            issue_left <= BYTE_CALC_W'(last_f[FRAME_CALC_W-1:3]) -
                          BYTE_CALC_W'(first_f[FRAME_CALC_W-1:3]) + BYTE_CALC_W'(1);
          end
        end
        ST_MARK, ST_SEARCH: begin
          rd_pend   <= mem_re;
          pend_addr <= rd_addr[BYTE_W-1:0];
          if (mem_re) begin
            rd_addr    <= addr_adv;
            issue_left <= issue_left - BYTE_CALC_W'(1);
          end
          if (state == ST_SEARCH && hit) begin
            res_addr    <= 32'({pend_addr, zero_bit}) << 12;
            res_granted <= 1'b1;
            last_hit    <= pend_addr;
            grant_count <= grant_count + 32'd1;
          end
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_addr      <= res_addr;
            out_granted   <= res_granted;
            out_count     <= grant_count;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[src/bpfa_checker.sv]
// Port-level checker for the bitmap page frame allocator, bound to the top.
// Depends on bpfa_pkg for the stream data widths.
// Checks output hold, result field consistency and the grant count sequence.
module bpfa_checker
  import bpfa_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic        seen;
  logic [31:0] last_total;
  logic        out_xfer;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= 1'b0;
      last_total <= '0;
    end else if (out_xfer) begin
      seen       <= 1'b1;
      last_total <= m_axis_tdata[64:33];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
    else $error("frame address nonzero without a grant");

  a_page_aligned: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[11:0] == 12'd0)
    else $error("frame address not page aligned");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_xfer && seen |-> m_axis_tdata[64:33] == last_total + 32'(m_axis_tdata[32]))
    else $error("grant count does not follow the grant flags");

  a_first_count: assert property (@(posedge clk) disable iff (rst)
    out_xfer && !seen |-> m_axis_tdata[64:33] == 32'(m_axis_tdata[32]))
    else $error("first grant count after reset is wrong");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[bench/bpfa_grant_checker.sv]
`timescale 1ns / 1ps
// Checker for the bitmap page frame allocator: watches the config, command and result channels.
// It keeps its own copy of the frame bitmap, predicts each result and compares it field by field.
// Depends on bpfa_pkg for the command codes and the stream data widths.
module bpfa_grant_checker
  import bpfa_pkg::*;
#(
  parameter int unsigned NUM_FRAMES   = 65536,
  parameter int unsigned BITMAP_BYTES = 8192
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [15:0]           cfg_data,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int unsigned           fail_count,
  output int unsigned           pending
);

  typedef struct {
    logic [31:0] frame_address;
    logic        granted;
    logic [31:0] grants_total;
  } grant_result_t;

  logic [7:0]    frame_map [BITMAP_BYTES];
  logic [15:0]   low_frame;
  int unsigned   top_freed;
  int unsigned   last_byte;
  logic [31:0]   grant_count;
  grant_result_t expected_grants [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic take_frame(input int unsigned b, output logic [31:0] addr);
    int i;
    take_frame = 1'b0;
    addr = '0;
    if (frame_map[b] != 8'hFF) begin
      for (i = 0; i < 8; i++) begin
        if (!take_frame && !frame_map[b][i]) begin
          frame_map[b][i] = 1'b1;
          grant_count = grant_count + 1;
          last_byte = b;
          addr = (b * 8 + i) << 12;
          take_frame = 1'b1;
        end
      end
    end
  endfunction

  function automatic grant_result_t apply_frame_command(input cmd_t cmd, input logic [31:0] base,
                                                        input logic [31:0] len);
    grant_result_t r;
    logic [63:0] first;
    logic [63:0] stop;
    logic [63:0] f;
    logic [31:0] end_addr;
    logic [31:0] addr;
    logic        hit;
    int unsigned lo;
    int unsigned hi;
    int unsigned cur;
    int unsigned b;
    hit = 1'b0;
    addr = '0;
    case (cmd)
      CMD_MARK_USED: begin
        first = 64'(base) >> 12;
        stop = first + ((64'(len) + 64'hFFF) >> 12);
        if (stop > NUM_FRAMES) stop = NUM_FRAMES;
        for (f = first; f < stop; f++) begin
          if ((f >> 3) < BITMAP_BYTES) frame_map[f >> 3][f[2:0]] = 1'b1;
        end
      end
      CMD_MARK_FREE: begin
        end_addr = base + len;
        first = (64'(base) + 64'hFFF) >> 12;
        stop = 64'(end_addr) >> 12;
        if (stop > NUM_FRAMES) stop = NUM_FRAMES;
        for (f = first; f < stop; f++) begin
          if ((f >> 3) < BITMAP_BYTES) frame_map[f >> 3][f[2:0]] = 1'b0;
          if (f > top_freed) top_freed = 32'(f);
        end
      end
      CMD_ALLOCATE: begin
        lo = low_frame >> 3;
        hi = (top_freed >> 3) + 1;
        if (hi > BITMAP_BYTES) hi = BITMAP_BYTES;
        cur = last_byte;
        if (cur < lo || cur >= hi) cur = lo;
        for (b = cur; b < hi && !hit; b++) hit = take_frame(b, addr);
        for (b = lo; b < cur && b < hi && !hit; b++) hit = take_frame(b, addr);
      end
      default: begin
      end
    endcase
    r.frame_address = hit ? addr : 32'd0;
    r.granted = hit;
    r.grants_total = grant_count;
    return r;
  endfunction

  always @(posedge clk) begin
    grant_result_t want;
    if (rst) begin
      foreach (frame_map[i]) frame_map[i] = 8'hFF;
      low_frame = '0;
      top_freed = 0;
      last_byte = 0;
      grant_count = '0;
      expected_grants.delete();
    end else begin
      if (cfg_valid && cfg_ready) low_frame = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_grants.push_back(apply_frame_command(cmd_t'(s_axis_tdata[1:0]),
                                                      s_axis_tdata[33:2], s_axis_tdata[65:34]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_grants.size() == 0) begin
          $error("result transaction with no command waiting: %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_grants.pop_front();
          if (m_axis_tdata[31:0] !== want.frame_address) begin
            $error("frame_address: expected %h, got %h", want.frame_address,
                   m_axis_tdata[31:0]);
            fail_count++;
          end
          if (m_axis_tdata[32] !== want.granted) begin
            $error("granted: expected %b, got %b", want.granted, m_axis_tdata[32]);
            fail_count++;
          end
          if (m_axis_tdata[64:33] !== want.grants_total) begin
            $error("grants_total: expected %0d, got %0d", want.grants_total,
                   m_axis_tdata[64:33]);
            fail_count++;
          end
        end
      end
    end
    pending = expected_grants.size();
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, command and config stimulus, result backpressure.
// Depends on bpfa_pkg, the bitmap_page_frame_allocator block and the bpfa_grant_checker module.
module tb;
  import bpfa_pkg::*;

  localparam int unsigned REGION_FRAME   = 64512;
  localparam int unsigned PHASE_ITEMS    = 630;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned TAIL_CYCLES    = 32;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [15:0]           cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned sender_idle_pct = 19;
  int unsigned receiver_idle_pct = 87;
  int unsigned quiet_cycles = 0;
  bit          hold_off_req = 1'b0;

  bitmap_page_frame_allocator DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bpfa_grant_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (mismatch_count),
    .pending       (pending_results)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_command(input cmd_t cmd, input logic [31:0] base, input logic [31:0] len);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, len, base, cmd};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
  endtask

  task automatic write_lowest_frame(input logic [15:0] frame);
    cfg_valid <= 1'b1;
    cfg_data <= frame;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic in the top kilo-frame region, with a little full-range noise.
  task automatic send_random_command();
    int unsigned pick;
    int unsigned frame;
    cmd_t        cmd;
    logic [31:0] base;
    logic [31:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      cmd = cmd_t'($urandom_range(0, 3));
      base = $urandom;
      len = $urandom;
    end else begin
      if (pick < 44) cmd = CMD_ALLOCATE;
      else if (pick < 74) cmd = CMD_MARK_FREE;
      else if (pick < 99) cmd = CMD_MARK_USED;
      else cmd = CMD_NONE;
      frame = REGION_FRAME + $urandom_range(0, 1023);
      base = frame << 12;
      if ($urandom_range(0, 3) != 0) base[11:0] = 12'($urandom_range(0, 4095));
      len = $urandom_range(0, 64 * 4096);
      if ($urandom_range(0, 3) == 0) len[11:0] = 12'h000;
    end
    send_command(cmd, base, len);
  endtask

  initial begin
    int unsigned k;
    int unsigned mode;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_lowest_frame(16'd0);
    send_command(CMD_ALLOCATE, 32'h0, 32'h0);
    send_command(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(CMD_MARK_FREE, 32'h0, 32'h0);
    send_command(CMD_MARK_FREE, 32'h0, 32'h8000);
    send_command(CMD_ALLOCATE, 32'h0, 32'h0);
    send_command(CMD_ALLOCATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(CMD_MARK_USED, 32'h0, 32'h0);
    send_command(CMD_MARK_USED, 32'h0000_2FFF, 32'h1);
    send_command(CMD_MARK_FREE, 32'h0000_5000, 32'hFFFF_F000);
    send_command(CMD_MARK_FREE, 32'h1, 32'h2FFF);
    send_command(CMD_MARK_USED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(CMD_MARK_FREE, 32'hFFFF_F001, 32'hFFFF_FFFF);
    drain_results();

    write_lowest_frame(16'd8);
    send_command(CMD_ALLOCATE, 32'h0, 32'h0);
    drain_results();

    write_lowest_frame(16'hFFFF);
    send_command(CMD_MARK_FREE, 32'h0FFF_0000, 32'h0002_0000);
    send_command(CMD_ALLOCATE, 32'h0, 32'h0);
    send_command(CMD_ALLOCATE, 32'h0, 32'h0);
    send_command(CMD_MARK_USED, 32'h0, 32'hFFFF_FFFF);
    send_command(CMD_ALLOCATE, 32'h0, 32'h0);
    drain_results();

    write_lowest_frame(16'd0);
    send_command(CMD_ALLOCATE, 32'h0, 32'h0);
    send_command(CMD_MARK_FREE, 32'h0000_3000, 32'h1000);
    send_command(CMD_ALLOCATE, 32'h0, 32'h0);
    send_command(CMD_MARK_FREE, 32'h0, 32'hFFFF_FFFF);
    drain_results();

    for (mode = 0; mode < 3; mode++) begin
      if (mode == 0) begin
        sender_idle_pct = 19;
        receiver_idle_pct = 87;
      end else if (mode == 1) begin
        sender_idle_pct = 87;
        receiver_idle_pct = 19;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      write_lowest_frame(16'(REGION_FRAME + $urandom_range(0, 1023)));
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (mode == 2 && k == 50) hold_off_req = 1'b1;
        send_random_command();
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
